FILE: rtl/cic_pkg.sv
// ----------------------------------------------------------------------------
// cic_pkg
// Shared types and constants of the cloud-in-cell density deposit block.
// ----------------------------------------------------------------------------
package cic_pkg;

    // Default grid side, in cells.
    localparam int GRID_SIDE_DEF = 32;

    // Field widths.
    localparam int CELL_W = 5;
    localparam int DISP_W = 32;
    localparam int INV_W  = 24;
    localparam int DENS_W = 32;

    // Reset value of the scale register: 1.0 in Q8.16.
    localparam logic [INV_W-1:0] INV_RESET = 24'h010000;

    // Position arithmetic: product, position in Q.16 and integer cell index.
    localparam int PROD_W = DISP_W + INV_W + 1;
    localparam int POS_W  = 42;
    localparam int BASE_W = 26;

    // Modulo unit: the lifted, non-negative index is one bit wider.
    localparam int MOD_W = BASE_W + 1;

    // Weights and their products.
    localparam int WGT_W  = 17;
    localparam int FRAC_W = 16;

    // Function codes of an input beat.
    localparam logic [1:0] FUNC_DEPOSIT    = 2'd0;
    localparam logic [1:0] FUNC_READ       = 2'd1;
    localparam logic [1:0] FUNC_READ_CLEAR = 2'd2;
    localparam logic [1:0] FUNC_RESERVED   = 2'd3;

    // Axis indexes.
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // Last corner of the trilinear stencil.
    localparam logic [2:0] CORNER_LAST = 3'd7;

    // Controller states.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_POS,
        ST_MOD_START,
        ST_MOD_WAIT,
        ST_CORNER_SETUP,
        ST_WEIGHT,
        ST_MEM_RD,
        ST_MEM_WR,
        ST_READ_WAIT,
        ST_READ_RD,
        ST_READ_OUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       clr_step;
        logic       load;
        logic       pos_load;
        logic       mod_start;
        logic       axis_store;
        logic       corner_setup;
        logic       weight_mul;
        logic       mem_rd;
        logic       acc_write;
        logic       zero_write;
        logic       out_load;
        logic [1:0] axis;
        logic [2:0] corner;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic mod_busy;
        logic is_deposit;
        logic is_read;
        logic is_read_clear;
        logic out_full;
    } status_t;

endpackage

FILE: rtl/cic_mod.sv
// ----------------------------------------------------------------------------
// cic_mod
// Reduction of a signed cell index modulo the grid side by reciprocal
// multiplication, in a three-stage pipeline.
// ----------------------------------------------------------------------------
module cic_mod #(
    parameter int GRID_SIDE = cic_pkg::GRID_SIDE_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [cic_pkg::BASE_W-1:0] value,
    output logic                              busy,
    output logic [$clog2(GRID_SIDE)-1:0]      result
);

    localparam int IDX_W = $clog2(GRID_SIDE);
    localparam int U_W   = cic_pkg::MOD_W;
    localparam int P_W   = 2 * U_W;

    // Smallest multiple of the grid side that lifts any index to zero or above.
    localparam longint LIFT_VAL =
        ((longint'(1) << (cic_pkg::BASE_W - 1)) + longint'(GRID_SIDE) - 1)
        / longint'(GRID_SIDE) * longint'(GRID_SIDE);
    localparam logic [U_W-1:0] LIFT   = U_W'(LIFT_VAL);
    // Reciprocal of the grid side scaled by 2^U_W, rounded down. The quotient
    // estimate is then short by at most one.
    localparam logic [U_W-1:0] RECIP  = U_W'((longint'(1) << U_W) / longint'(GRID_SIDE));
    localparam logic [U_W-1:0] SIDE_U = U_W'(GRID_SIDE);
    localparam logic [IDX_W:0] SIDE_R = (IDX_W + 1)'(GRID_SIDE);

    logic [U_W-1:0]   lifted;
    logic [U_W-1:0]   u_reg;
    logic [U_W-1:0]   q_reg;
    logic [P_W-1:0]   qprod;
    logic [U_W-1:0]   rem_full;
    logic [IDX_W:0]   rem_reg;
    logic [IDX_W:0]   rem_sub;
    logic [IDX_W-1:0] idx_reg;
    logic [2:0]       stage_reg, stage_next;

    // Sign-extend the index and add the lift.
    assign lifted = U_W'(value) + LIFT;

    // Quotient estimate, remainder below twice the side, final correction.
    assign qprod    = P_W'(u_reg) * P_W'(RECIP);
    assign rem_full = u_reg - q_reg * SIDE_U;
    assign rem_sub  = rem_reg - SIDE_R;

    // One pending flag per pipeline stage.
    assign stage_next = {stage_reg[1:0], start};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else
        begin
            stage_reg <= stage_next;
        end
    end

    // Pipeline data.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            u_reg <= lifted;
        end
        q_reg   <= qprod[P_W-1:U_W];
        rem_reg <= rem_full[IDX_W:0];
        idx_reg <= (rem_reg >= SIDE_R) ? rem_sub[IDX_W-1:0] : rem_reg[IDX_W-1:0];
    end

    assign busy   = |stage_reg;
    assign result = idx_reg;

endmodule

FILE: rtl/cic_dp.sv
// ----------------------------------------------------------------------------
// cic_dp
// Datapath: input registers, position scaling, weights, density memory and
// the result register.
// ----------------------------------------------------------------------------
module cic_dp #(
    parameter int GRID_SIDE = cic_pkg::GRID_SIDE_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [cic_pkg::INV_W-1:0]         cfg_wr_data,
    input  logic [1:0]                        func,
    input  logic [cic_pkg::CELL_W-1:0]        cell_x,
    input  logic [cic_pkg::CELL_W-1:0]        cell_y,
    input  logic [cic_pkg::CELL_W-1:0]        cell_z,
    input  logic signed [cic_pkg::DISP_W-1:0] disp_x,
    input  logic signed [cic_pkg::DISP_W-1:0] disp_y,
    input  logic signed [cic_pkg::DISP_W-1:0] disp_z,
    input  logic                              out_stall,
    input  cic_pkg::cmd_t                     cmd,
    output cic_pkg::status_t                  status,
    output logic                              out_valid,
    output logic [cic_pkg::DENS_W-1:0]        cell_density,
    output logic                              overflow_seen
);

    localparam int IDX_W  = $clog2(GRID_SIDE);
    localparam int CELLS  = GRID_SIDE * GRID_SIDE * GRID_SIDE;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int SIDE2  = GRID_SIDE * GRID_SIDE;
    localparam int WAB_W  = 2 * cic_pkg::WGT_W;
    localparam int WABC_W = 3 * cic_pkg::WGT_W;

    // Configuration and input beat registers.
    logic [cic_pkg::INV_W-1:0]         inv_reg;
    logic [1:0]                        func_reg;
    logic [cic_pkg::CELL_W-1:0]        cell_reg [3];
    logic signed [cic_pkg::DISP_W-1:0] disp_reg [3];

    // Per-axis results.
    logic signed [cic_pkg::POS_W-1:0]  pos_reg;
    logic [IDX_W-1:0]                  lo_reg [3];
    logic [IDX_W-1:0]                  hi_reg [3];
    logic [cic_pkg::FRAC_W-1:0]        frac_reg [3];

    // Corner registers.
    logic [WAB_W-1:0]                  wab_reg;
    logic [cic_pkg::WGT_W-1:0]         wt_reg;
    logic [ADDR_W-1:0]                 addr_reg;
    logic [ADDR_W-1:0]                 clr_addr_reg;
    logic [cic_pkg::DENS_W-1:0]        rdata_reg;
    logic                              ovf_reg;
    logic                              out_valid_reg, out_valid_next;
    logic [cic_pkg::DENS_W-1:0]        dens_reg;
    logic                              ovf_out_reg;

    // Density store.
    logic [cic_pkg::DENS_W-1:0]        grid_mem [CELLS];

    logic signed [cic_pkg::DISP_W-1:0] disp_sel;
    logic [cic_pkg::CELL_W-1:0]        cell_sel;
    logic signed [cic_pkg::PROD_W-1:0] prod;
    logic signed [cic_pkg::POS_W-1:0]  pos_next;
    logic [IDX_W-1:0]                  mod_result;
    logic                              mod_busy;
    logic [IDX_W-1:0]                  cx, cy, cz;
    logic [cic_pkg::WGT_W-1:0]         wx, wy, wz;
    logic [WABC_W-1:0]                 wabc;
    logic [cic_pkg::DENS_W:0]          sum;
    logic                              mem_we;
    logic [ADDR_W-1:0]                 mem_waddr;
    logic [cic_pkg::DENS_W-1:0]        mem_wdata;

    // Weight of one axis: the fraction for the upper corner, its complement
    // for the lower one.
    function automatic logic [cic_pkg::WGT_W-1:0] weight(
        input logic [cic_pkg::FRAC_W-1:0] f,
        input logic                       upper
    );
        logic [cic_pkg::WGT_W-1:0] w;
        if (upper)
        begin
            w = {1'b0, f};
        end
        else
        begin
            w = cic_pkg::WGT_W'(1 << cic_pkg::FRAC_W) - {1'b0, f};
        end
        return w;
    endfunction

    // Scale register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_reg <= cic_pkg::INV_RESET;
        end
        else if (cfg_wr_en)
        begin
            inv_reg <= cfg_wr_data;
        end
    end

    // Capture of the accepted input beat.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg    <= func;
            cell_reg[0] <= cell_x;
            cell_reg[1] <= cell_y;
            cell_reg[2] <= cell_z;
            disp_reg[0] <= disp_x;
            disp_reg[1] <= disp_y;
            disp_reg[2] <= disp_z;
        end
    end

    // Position in cells for the current axis; a read uses the cell alone.
    always_comb
    begin
        disp_sel = status.is_deposit ? disp_reg[cmd.axis] : '0;
        cell_sel = cell_reg[cmd.axis];
        prod     = disp_sel * $signed({1'b0, inv_reg});
        pos_next = cic_pkg::POS_W'($signed(prod[cic_pkg::PROD_W-1:cic_pkg::FRAC_W]))
                 + $signed(cic_pkg::POS_W'({cell_sel, {cic_pkg::FRAC_W{1'b0}}}));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pos_load)
        begin
            pos_reg <= pos_next;
        end
    end

    // Periodic wrap of the floored index.
    cic_mod #(
        .GRID_SIDE (GRID_SIDE)
    ) u_mod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.mod_start),
        .value  (pos_reg[cic_pkg::POS_W-1 -: cic_pkg::BASE_W]),
        .busy   (mod_busy),
        .result (mod_result)
    );

    // Store the wrapped lower index, its neighbor and the fraction.
    always_ff @(posedge clk)
    begin
        if (cmd.axis_store)
        begin
            lo_reg[cmd.axis]   <= mod_result;
            hi_reg[cmd.axis]   <= (mod_result == IDX_W'(GRID_SIDE - 1))
                                ? '0 : mod_result + 1'b1;
            frac_reg[cmd.axis] <= pos_reg[cic_pkg::FRAC_W-1:0];
        end
    end

    // Corner coordinates and weights.
    always_comb
    begin
        cx   = cmd.corner[2] ? hi_reg[0] : lo_reg[0];
        cy   = cmd.corner[1] ? hi_reg[1] : lo_reg[1];
        cz   = cmd.corner[0] ? hi_reg[2] : lo_reg[2];
        wx   = weight(frac_reg[0], cmd.corner[2]);
        wy   = weight(frac_reg[1], cmd.corner[1]);
        wz   = weight(frac_reg[2], cmd.corner[0]);
        wabc = WABC_W'(wab_reg) * WABC_W'(wz);
    end

    // First weight product, the cell address and the full corner weight.
    always_ff @(posedge clk)
    begin
        if (cmd.corner_setup)
        begin
            wab_reg  <= WAB_W'(wx) * WAB_W'(wy);
            addr_reg <= ADDR_W'(cx) * ADDR_W'(SIDE2) + ADDR_W'(cy) * ADDR_W'(GRID_SIDE)
                      + ADDR_W'(cz);
        end
        if (cmd.weight_mul)
        begin
            wt_reg <= wabc[2*cic_pkg::FRAC_W +: cic_pkg::WGT_W];
        end
    end

    // Saturating accumulation.
    assign sum = {1'b0, rdata_reg} + (cic_pkg::DENS_W + 1)'(wt_reg);

    // Memory write port: clearing pass, accumulation or read-and-clear.
    always_comb
    begin
        mem_we    = cmd.clr_step | cmd.acc_write | cmd.zero_write;
        mem_waddr = cmd.clr_step ? clr_addr_reg : addr_reg;
        if (cmd.acc_write)
        begin
            mem_wdata = sum[cic_pkg::DENS_W] ? '1 : sum[cic_pkg::DENS_W-1:0];
        end
        else
        begin
            mem_wdata = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            grid_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.mem_rd)
        begin
            rdata_reg <= grid_mem[addr_reg];
        end
    end

    // Clearing pass counter and sticky saturation flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            ovf_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.acc_write && sum[cic_pkg::DENS_W])
            begin
                ovf_reg <= 1'b1;
            end
        end
    end

    // Result register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // The flag is captured with the cell value so that later deposits do not
    // change a waiting result.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            dens_reg    <= rdata_reg;
            ovf_out_reg <= ovf_reg;
        end
    end

    // Status toward the controller.
    always_comb
    begin
        status.clr_last      = (clr_addr_reg == ADDR_W'(CELLS - 1));
        status.mod_busy      = mod_busy;
        status.is_deposit    = (func_reg == cic_pkg::FUNC_DEPOSIT);
        status.is_read       = (func_reg == cic_pkg::FUNC_READ);
        status.is_read_clear = (func_reg == cic_pkg::FUNC_READ_CLEAR);
        status.out_full      = out_valid_reg & out_stall;
    end

    assign out_valid     = out_valid_reg;
    assign cell_density  = dens_reg;
    assign overflow_seen = ovf_out_reg;

endmodule

FILE: rtl/cic_ctrl.sv
// ----------------------------------------------------------------------------
// cic_ctrl
// Controller: clearing pass, per-axis position and wrap, eight corner
// read-modify-writes, and cell reads.
// ----------------------------------------------------------------------------
module cic_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  cic_pkg::status_t status,
    output cic_pkg::cmd_t    cmd
);

    cic_pkg::state_t state_reg, state_next;
    logic [1:0]      axis_reg, axis_next;
    logic [2:0]      corner_reg, corner_next;

    // State and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= cic_pkg::ST_CLEAR;
            axis_reg   <= cic_pkg::AXIS_X;
            corner_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            axis_reg   <= axis_next;
            corner_reg <= corner_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next  = state_reg;
        axis_next   = axis_reg;
        corner_next = corner_reg;
        case (state_reg)
            cic_pkg::ST_CLEAR:
            begin
                if (status.clr_last)
                begin
                    state_next = cic_pkg::ST_IDLE;
                end
            end
            cic_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = cic_pkg::ST_DECODE;
                end
            end
            cic_pkg::ST_DECODE:
            begin
                axis_next   = cic_pkg::AXIS_X;
                corner_next = '0;
                if (status.is_deposit || status.is_read || status.is_read_clear)
                begin
                    state_next = cic_pkg::ST_POS;
                end
                else
                begin
                    state_next = cic_pkg::ST_IDLE;
                end
            end
            cic_pkg::ST_POS:
            begin
                state_next = cic_pkg::ST_MOD_START;
            end
            cic_pkg::ST_MOD_START:
            begin
                state_next = cic_pkg::ST_MOD_WAIT;
            end
            cic_pkg::ST_MOD_WAIT:
            begin
                if (!status.mod_busy)
                begin
                    if (axis_reg != cic_pkg::AXIS_Z)
                    begin
                        axis_next  = axis_reg + 1'b1;
                        state_next = cic_pkg::ST_POS;
                    end
                    else if (status.is_deposit)
                    begin
                        state_next = cic_pkg::ST_CORNER_SETUP;
                    end
                    else
                    begin
                        state_next = cic_pkg::ST_READ_WAIT;
                    end
                end
            end
            cic_pkg::ST_CORNER_SETUP:
            begin
                state_next = cic_pkg::ST_WEIGHT;
            end
            cic_pkg::ST_WEIGHT:
            begin
                state_next = cic_pkg::ST_MEM_RD;
            end
            cic_pkg::ST_MEM_RD:
            begin
                state_next = cic_pkg::ST_MEM_WR;
            end
            cic_pkg::ST_MEM_WR:
            begin
                if (corner_reg == cic_pkg::CORNER_LAST)
                begin
                    state_next = cic_pkg::ST_IDLE;
                end
                else
                begin
                    corner_next = corner_reg + 1'b1;
                    state_next  = cic_pkg::ST_CORNER_SETUP;
                end
            end
            cic_pkg::ST_READ_WAIT:
            begin
                if (!status.out_full)
                begin
                    state_next = cic_pkg::ST_READ_RD;
                end
            end
            cic_pkg::ST_READ_RD:
            begin
                state_next = cic_pkg::ST_READ_OUT;
            end
            cic_pkg::ST_READ_OUT:
            begin
                state_next = cic_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = cic_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        cmd          = '0;
        cmd.axis     = axis_reg;
        cmd.corner   = corner_reg;
        in_stall     = (state_reg != cic_pkg::ST_IDLE);
        case (state_reg)
            cic_pkg::ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
            end
            cic_pkg::ST_IDLE:
            begin
                cmd.load = in_valid;
            end
            cic_pkg::ST_POS:
            begin
                cmd.pos_load = 1'b1;
            end
            cic_pkg::ST_MOD_START:
            begin
                cmd.mod_start = 1'b1;
            end
            cic_pkg::ST_MOD_WAIT:
            begin
                cmd.axis_store = !status.mod_busy;
            end
            cic_pkg::ST_CORNER_SETUP:
            begin
                cmd.corner_setup = 1'b1;
            end
            cic_pkg::ST_WEIGHT:
            begin
                cmd.weight_mul = 1'b1;
            end
            cic_pkg::ST_MEM_RD:
            begin
                cmd.mem_rd = 1'b1;
            end
            cic_pkg::ST_MEM_WR:
            begin
                cmd.acc_write = 1'b1;
            end
            cic_pkg::ST_READ_WAIT:
            begin
                cmd.corner_setup = 1'b1;
            end
            cic_pkg::ST_READ_RD:
            begin
                cmd.mem_rd = 1'b1;
            end
            cic_pkg::ST_READ_OUT:
            begin
                cmd.out_load   = 1'b1;
                cmd.zero_write = status.is_read_clear;
            end
            default:
            begin
                cmd.load = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/cloud_in_cell_deposit.sv
// ----------------------------------------------------------------------------
// cloud_in_cell_deposit
// Cloud-in-cell mass assignment onto a periodic cubic density grid.
// ----------------------------------------------------------------------------
// After reset the block clears its GRID_SIDE^3-word density memory, one word
// per cycle, and takes no beat until that pass is done. It then works on one
// beat at a time. After the accepting edge there is a decode state, then for
// each axis the position, the start of the modulo unit and a wait through its
// three pipeline stages of a reciprocal multiplication, ending in the store of
// the wrapped index. A deposit adds the eight corner read-modify-writes, each
// as corner setup, weight, memory read and memory write, before the next beat
// is accepted. A read result is loaded into an output register on the way
// back to idle, so the next beat can be accepted while it waits to be taken;
// a later read then waits until that register is free.
module cloud_in_cell_deposit #(
    parameter int GRID_SIDE = cic_pkg::GRID_SIDE_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [cic_pkg::INV_W-1:0]         cfg_wr_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        func,
    input  logic [cic_pkg::CELL_W-1:0]        cell_x,
    input  logic [cic_pkg::CELL_W-1:0]        cell_y,
    input  logic [cic_pkg::CELL_W-1:0]        cell_z,
    input  logic signed [cic_pkg::DISP_W-1:0] disp_x,
    input  logic signed [cic_pkg::DISP_W-1:0] disp_y,
    input  logic signed [cic_pkg::DISP_W-1:0] disp_z,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [cic_pkg::DENS_W-1:0]        cell_density,
    output logic                              overflow_seen
);

    cic_pkg::cmd_t    cmd;
    cic_pkg::status_t status;

    // Sequencer.
    cic_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Arithmetic and storage.
    cic_dp #(
        .GRID_SIDE (GRID_SIDE)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .func          (func),
        .cell_x        (cell_x),
        .cell_y        (cell_y),
        .cell_z        (cell_z),
        .disp_x        (disp_x),
        .disp_y        (disp_y),
        .disp_z        (disp_z),
        .out_stall     (out_stall),
        .cmd           (cmd),
        .status        (status),
        .out_valid     (out_valid),
        .cell_density  (cell_density),
        .overflow_seen (overflow_seen)
    );

endmodule
